@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bounded integer stack.
// ----------------------------------------------------------------------------
package bis_pkg;

	// data path and register widths
	localparam int DATA_W  = 32;
	localparam int KIND_W  = 3;
	localparam int CAP_W   = 7;
	localparam int PADDR_W = 3;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// register index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	// operation codes carried by a command beat
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH      = 3'd0,
		KIND_POP       = 3'd1,
		KIND_TOP       = 3'd2,
		KIND_DUMP_DOWN = 3'd3,
		KIND_DUMP_UP   = 3'd4
	} kind_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

endpackage

@@ rtl/bis_if.sv @@
// ----------------------------------------------------------------------------
// bis_if
// Valid/ready channels of the bounded integer stack: command and response.
// ----------------------------------------------------------------------------
interface bis_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic signed [31:0] push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface bis_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] entry_value;
	logic               last_of_run;

	modport source (output valid, output entry_value, output last_of_run, input ready);
	modport sink   (input valid, input entry_value, input last_of_run, output ready);
endinterface

@@ rtl/bis_cfg.sv @@
// ----------------------------------------------------------------------------
// bis_cfg
// APB-style register block holding the stack capacity.
// ----------------------------------------------------------------------------
module bis_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bis_pkg::PADDR_W-1:0]  paddr,
	input  logic [bis_pkg::DATA_W-1:0]   pwdata,
	output logic [bis_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [bis_pkg::CAP_W-1:0]    capacity
);
	import bis_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             hit;

	// register select from the word address
	assign hit    = (paddr[2] == REG_CAPACITY);
	assign pready = 1'b1;

	// capacity register, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = DATA_W'(capacity_q);
		end
	end

	assign capacity = capacity_q;

endmodule

@@ rtl/bis_store.sv @@
// ----------------------------------------------------------------------------
// bis_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bis_store #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [bis_pkg::DATA_W-1:0]  wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [bis_pkg::DATA_W-1:0]  rdata
);
	import bis_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bis_ctrl
// Stack sequencer: fill count, memory accesses, dump walk and response register.
// ----------------------------------------------------------------------------
module bis_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bis_in_if.sink                      cmd,
	bis_out_if.source                   rsp,
	input  logic [bis_pkg::CAP_W-1:0]   capacity,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_waddr,
	output logic [bis_pkg::DATA_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(DEPTH)-1:0]    mem_raddr,
	input  logic [bis_pkg::DATA_W-1:0]  mem_rdata
);
	import bis_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [FW-1:0]     remain_q, remain_d;
	logic [AW-1:0]     addr_q, addr_d;
	logic              dir_up_q, dir_up_d;
	logic              out_valid_q;
	logic [DATA_W-1:0] entry_q;
	logic              last_q;

	logic              accept;
	logic              start_run;
	logic              load;
	logic              is_last;
	logic              slot_free;
	logic              push_ok;
	logic              not_empty;
	logic [AW-1:0]     top_addr;
	logic [AW-1:0]     step_addr;
	kind_t             kind;

	assign kind      = kind_t'(cmd.kind);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign not_empty = (fill_q != '0);
	assign push_ok   = (32'(fill_q) < 32'(capacity)) && (32'(fill_q) < DEPTH);
	assign top_addr  = AW'(fill_q - FW'(1));
	assign step_addr = dir_up_q ? (addr_q + AW'(1)) : (addr_q - AW'(1));
	assign is_last   = (remain_q == FW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_run) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		cmd.ready = 1'b0;
		start_run = 1'b0;
		load      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = cmd.push_value;
		mem_re    = 1'b0;
		mem_raddr = top_addr;
		fill_d    = fill_q;
		remain_d  = remain_q;
		addr_d    = addr_q;
		dir_up_d  = dir_up_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (accept) begin
					case (kind) inside
						KIND_PUSH: begin
							if (push_ok) begin
								mem_we = 1'b1;
								fill_d = fill_q + FW'(1);
							end
						end
						KIND_POP: begin
							if (not_empty) begin
								fill_d = fill_q - FW'(1);
							end
						end
						KIND_TOP, KIND_DUMP_DOWN: begin
							if (not_empty) begin
								start_run = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = top_addr;
								addr_d    = top_addr;
								dir_up_d  = 1'b0;
								remain_d  = (kind == KIND_TOP) ? FW'(1) : fill_q;
							end
						end
						KIND_DUMP_UP: begin
							if (not_empty) begin
								start_run = 1'b1;
								mem_re    = 1'b1;
								mem_raddr = '0;
								addr_d    = '0;
								dir_up_d  = 1'b1;
								remain_d  = fill_q;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				// landed word moves to the response register, next read follows
				if (slot_free) begin
					load = 1'b1;
					if (!is_last) begin
						mem_re    = 1'b1;
						mem_raddr = step_addr;
						addr_d    = step_addr;
						remain_d  = remain_q - FW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			remain_q <= remain_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk and response payload
	always_ff @(posedge clk) begin
		addr_q   <= addr_d;
		dir_up_q <= dir_up_d;
		if (load) begin
			entry_q <= mem_rdata;
			last_q  <= is_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_value = entry_q;
	assign rsp.last_of_run = last_q;

	// fill count stays within the memory
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= DEPTH)
		else $error("fill count beyond depth");

	// no fill change while a read run is in progress
	a_fill_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (fill_q == $past(fill_q)))
		else $error("fill count moved during a run");

	// a run always has an entry left to report
	a_run_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (remain_q != '0))
		else $error("run with no entry left");

	// no memory write during a run
	a_run_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !mem_we)
		else $error("memory write during a run");

	// last beat of a run returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
		else $error("last beat did not close the run");

endmodule

@@ rtl/bounded_int_stack_top.sv @@
// ----------------------------------------------------------------------------
// bounded_int_stack_top
// Bounded LIFO stack of signed 32-bit values with an APB-set capacity.
// ----------------------------------------------------------------------------
// push and pop update the fill count as they are taken; the command port is ready again on the next cycle
// top: the entry goes through the store's read register, then the response register
// dumps: one result beat per entry, one cycle each while the sink takes them,
// set by the single read port of the entry memory; no command is taken during a run
// reset empties the stack at once and sets capacity to 64; memory needs no clearing
module bounded_int_stack_top #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bis_pkg::PADDR_W-1:0]  paddr,
	input  logic [bis_pkg::DATA_W-1:0]   pwdata,
	output logic [bis_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	bis_in_if.sink                       cmd,
	bis_out_if.source                    rsp
);
	import bis_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [CAP_W-1:0]  capacity;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// configuration registers
	bis_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// entry memory
	bis_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer
	bis_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.capacity  (capacity),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded integer stack. A short table of opening
// commands hits the empty stack, the value extremes, every operation and the
// unused codes; then randomised phases sweep the capacity register (zero,
// one, small, saturating, lowered under the fill level) under three idling
// patterns. Every beat is checked against a local stack model or a table value.
// ----------------------------------------------------------------------------
module testbench;
	import bis_pkg::*;

	localparam int DEPTH       = 64;
	localparam int NUM_PHASES  = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 4;

	// command codes the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

	// register map: capacity at 0, nothing behind the next slot
	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_SPARE    = 3'd4;

	localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] VAL_ONES = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
		logic              typed;
		logic [DATA_W-1:0] want;
	} opening_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	bis_in_if  cmd ();
	bis_out_if rsp ();

	bounded_int_stack_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// local copy of the stack
	logic [DATA_W-1:0] stack_mem [DEPTH];
	int unsigned       fill_level;
	logic [CAP_W-1:0]  capacity_reg;

	entry_t pending_entries[$];
	entry_t step_entries[$];
	entry_t head;

	int err_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_cycles;

	opening_row_t opening_rows [24];

	int phase_cap   [NUM_PHASES] = '{64, 1, 0, 127, 5, 2, 64, 3};
	int phase_push  [NUM_PHASES] = '{60, 40, 40, 90, 30, 50, 60, 40};
	int phase_items [NUM_PHASES] = '{40, 30, 25, 80, 40, 30, 40, 30};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stack model: one command in, the entries it reports out
	task automatic stack_apply(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] val);
		int unsigned n;
		int unsigned room;
		n = fill_level;
		room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
		step_entries.delete();
		case (op)
			KIND_PUSH: begin
				if (n < room) begin
					stack_mem[n] = val;
					fill_level = n + 1;
				end
			end
			KIND_POP: begin
				if (n > 0)
					fill_level = n - 1;
			end
			KIND_TOP: begin
				if (n > 0)
					step_entries.push_back(entry_t'{stack_mem[n-1], 1'b1});
			end
			KIND_DUMP_DOWN: begin
				for (int i = n; i > 0; i--)
					step_entries.push_back(entry_t'{stack_mem[i-1], i == 1});
			end
			KIND_DUMP_UP: begin
				for (int i = 0; i < n; i++)
					step_entries.push_back(entry_t'{stack_mem[i], i + 1 == n});
			end
			default: ;
		endcase
	endtask

	// one command beat, with a random gap ahead of it
	task automatic send_cmd(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] val,
			input logic typed, input logic [DATA_W-1:0] want);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd.valid      <= 1'b1;
		cmd.kind       <= op;
		cmd.push_value <= val;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		stack_apply(op, val);
		if (typed)
			pending_entries.push_back(entry_t'{want, 1'b1});
		else
			foreach (step_entries[i]) pending_entries.push_back(step_entries[i]);
	endtask

	// hold off until every expected beat is back and the block has settled
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write: setup then access, then the bus is released
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_CAPACITY)
			capacity_reg = data[CAP_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// random command, push share set per phase
	task automatic send_random(input int push_pct);
		logic [KIND_W-1:0] op;
		logic [DATA_W-1:0] val;
		int                roll;
		roll = $urandom_range(99);
		if (roll < push_pct)
			op = KIND_PUSH;
		else begin
			roll = $urandom_range(99);
			if (roll < 35)
				op = KIND_POP;
			else if (roll < 60)
				op = KIND_TOP;
			else if (roll < 75)
				op = KIND_DUMP_DOWN;
			else if (roll < 90)
				op = KIND_DUMP_UP;
			else
				op = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
		end
		case ($urandom_range(15))
			0:       val = VAL_MAX;
			1:       val = VAL_MIN;
			2:       val = VAL_ONES;
			3:       val = VAL_ZERO;
			default: val = $urandom;
		endcase
		send_cmd(op, val, 1'b0, VAL_ZERO);
	endtask

	// response side: check each beat, then roll the next ready
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got value %h last %b",
					$time, rsp.entry_value, rsp.last_of_run);
				err_count++;
			end else begin
				head = pending_entries.pop_front();
				if (rsp.entry_value !== head.value || rsp.last_of_run !== head.last) begin
					$display("%0t: beat mismatch, expected value %h last %b, got value %h last %b",
						$time, head.value, head.last, rsp.entry_value, rsp.last_of_run);
					err_count++;
				end
			end
		end
		rsp.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, stall_cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		cmd.valid      = 1'b0;
		cmd.kind       = KIND_PUSH;
		cmd.push_value = '0;
		fill_level     = 0;
		capacity_reg   = CAP_RESET;
		send_idle_pct  = 38;
		recv_idle_pct  = 83;
		foreach (stack_mem[i]) stack_mem[i] = '0;

		// opening commands: empty stack, extremes, every code
		opening_rows = '{
			'{KIND_TOP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_DUMP_DOWN, VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_DUMP_UP,   VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_POP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_PUSH,      VAL_MAX,  1'b0, VAL_ZERO},
			'{KIND_TOP,       VAL_ZERO, 1'b1, VAL_MAX},
			'{KIND_PUSH,      VAL_MIN,  1'b0, VAL_ZERO},
			'{KIND_TOP,       VAL_ZERO, 1'b1, VAL_MIN},
			'{KIND_PUSH,      VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_PUSH,      VAL_ONES, 1'b0, VAL_ZERO},
			'{KIND_TOP,       VAL_ZERO, 1'b1, VAL_ONES},
			'{KIND_DUMP_DOWN, VAL_ONES, 1'b0, VAL_ZERO},
			'{KIND_DUMP_UP,   VAL_MAX,  1'b0, VAL_ZERO},
			'{KIND_SPARE_LO,  VAL_MAX,  1'b0, VAL_ZERO},
			'{KIND_SPARE_MID, VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_SPARE_HI,  VAL_ONES, 1'b0, VAL_ZERO},
			'{KIND_TOP,       VAL_MIN,  1'b1, VAL_ONES},
			'{KIND_POP,       VAL_ONES, 1'b0, VAL_ZERO},
			'{KIND_POP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_TOP,       VAL_ZERO, 1'b1, VAL_MIN},
			'{KIND_POP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_POP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_POP,       VAL_ZERO, 1'b0, VAL_ZERO},
			'{KIND_DUMP_UP,   VAL_ZERO, 1'b0, VAL_ZERO}
		};

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[r])
			send_cmd(opening_rows[r].kind, opening_rows[r].value,
				opening_rows[r].typed, opening_rows[r].want);

		// random phases, each with its own capacity
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			if (p == 4)
				apb_write(ADDR_SPARE, 32'h0000_0001);
			apb_write(ADDR_CAPACITY, phase_cap[p]);
			if (p < 3) begin
				send_idle_pct = 38;
				recv_idle_pct = 83;
			end else if (p < 6) begin
				send_idle_pct = 83;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < phase_items[p]; k++) begin
				// in the first phase only, the sender holds off midway until the stack has drained its output
				if (p == 0 && k == phase_items[p] / 2)
					wait_idle();
				send_random(phase_push[p]);
			end
		end

		// drain
		cmd.valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_entries.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
